FILE: hw/rtl/tye_pkg.sv
// Shared types, constants and the angle output helper function of the tilt and yaw estimator.
package tye_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int LANE_W = 33;
   localparam int ANGLE_ACC_W = 25;
   localparam int ANGLE_OUT_W = 15;
   localparam int YAW_W = 25;
   localparam int YAW_OUT_W = 16;

   localparam logic [31:0] DT_LIMIT = 32'd1000;
   // The yaw step divides by 131000; the factor of eight is taken out first,
   // leaving a division by 16375 done with two exact reciprocal multiplications.
   localparam logic [13:0] SCALE_DIV = 14'd16375;
   localparam logic [12:0] ROUND_LOW = 13'd8187;
   localparam logic [25:0] RECIP_MAG = 26'd33572875;
   localparam logic [27:0] RECIP_REM = 28'd134291497;
   localparam logic signed [26:0] FULL_TURN = 27'sd23592960;
   localparam logic signed [16:0] ANGLE_LIMIT = 17'sd11520;

   localparam logic signed [ANGLE_ACC_W-1:0] ATAN_TAB [CORDIC_STAGES] = '{
      25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
      25'sd234379, 25'sd117304, 25'sd58666, 25'sd29335,
      25'sd14668, 25'sd7334, 25'sd3667, 25'sd1833,
      25'sd917, 25'sd458, 25'sd229, 25'sd115
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_START,
      ST_ROOT,
      ST_ROTATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic valid;
      logic zero;
      logic signed [LANE_W-1:0] x;
      logic signed [LANE_W-1:0] y;
      logic signed [ANGLE_ACC_W-1:0] z;
   } cordic_lane_type;

   // Rounds the angle accumulator to 1/128 degree and saturates it.
   function automatic logic signed [ANGLE_OUT_W-1:0] angle_out(
      input logic signed [ANGLE_ACC_W-1:0] z,
      input logic zero
   );
      logic signed [ANGLE_ACC_W:0] sum;
      logic signed [16:0] r;
      logic signed [ANGLE_OUT_W-1:0] res;
      sum = ANGLE_ACC_W'(z) + 26'sd256;
      r = 17'(sum >>> 9);
      if (zero) begin
         res = '0;
      end else if (r > ANGLE_LIMIT) begin
         res = ANGLE_OUT_W'(ANGLE_LIMIT);
      end else if (r < -ANGLE_LIMIT) begin
         res = ANGLE_OUT_W'(-ANGLE_LIMIT);
      end else begin
         res = r[ANGLE_OUT_W-1:0];
      end
      return res;
   endfunction

endpackage

FILE: hw/rtl/tye_isqrt.sv
// Iterative integer square root, two operand bits per cycle.
module tye_isqrt (
   input  logic        clock,
   input  logic        start,
   input  logic [31:0] operand,
   output logic [15:0] root
);
   import tye_pkg::*;

   logic [31:0] op_ff, op_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] root_ff, root_in;
   logic [18:0] rem2;
   logic [18:0] trial;

   always_comb begin
      rem2 = {rem_ff, op_ff[31:30]};
      trial = {1'b0, root_ff, 2'b01};
      op_in = {op_ff[29:0], 2'b00};
      if (rem2 >= trial) begin
         rem_in = 17'(rem2 - trial);
         root_in = {root_ff[14:0], 1'b1};
      end else begin
         rem_in = rem2[16:0];
         root_in = {root_ff[14:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff <= operand;
         rem_ff <= '0;
         root_ff <= '0;
      end else begin
         op_ff <= op_in;
         rem_ff <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root = root_ff;

endmodule

FILE: hw/rtl/tye_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its pipeline register.
module tye_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tye_pkg::cordic_lane_type lane_i,
   output tye_pkg::cordic_lane_type lane_o
);
   import tye_pkg::*;

   cordic_lane_type lane_ff, lane_in;
   logic signed [LANE_W-1:0] x, y, xs, ys;
   logic signed [ANGLE_ACC_W-1:0] z;

   always_comb begin
      x = lane_i.x;
      y = lane_i.y;
      z = lane_i.z;
      xs = x >>> STAGE;
      ys = y >>> STAGE;
      lane_in = lane_i;
      if (y >= 0) begin
         lane_in.x = x + ys;
         lane_in.y = y - xs;
         lane_in.z = z + ATAN_TAB[STAGE];
      end else begin
         lane_in.x = x - ys;
         lane_in.y = y + xs;
         lane_in.z = z - ATAN_TAB[STAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else begin
         lane_ff.valid <= lane_in.valid;
      end
      lane_ff.zero <= lane_in.zero;
      lane_ff.x <= lane_in.x;
      lane_ff.y <= lane_in.y;
      lane_ff.z <= lane_in.z;
   end

   assign lane_o = lane_ff;

endmodule

FILE: hw/rtl/tye_yaw.sv
// Yaw integrator: scaling by reciprocal multiplication, then accumulate and wrap.
module tye_yaw (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [25:0]              rate_dt,
   output logic [tye_pkg::YAW_OUT_W-1:0]   yaw_angle
);
   import tye_pkg::*;

   logic [3:0] phase_ff, phase_in;
   logic sign_ff, sign_in;
   logic [24:0] mag_ff, mag_in;
   logic [11:0] qm_ff, qm_in;
   logic [13:0] rm_ff, rm_in;
   logic [24:0] q_ff, q_in;
   logic [YAW_W-1:0] acc_ff, acc_in;
   logic [24:0] mag;
   logic [50:0] prod_mag;
   logic [25:0] qm_scaled;
   logic [24:0] rem_full;
   logic [54:0] prod_rem;
   logic signed [26:0] delta, yaw;
   logic [YAW_W-1:0] rounded;

   always_comb begin
      mag = rate_dt[25] ? 25'(-rate_dt) : rate_dt[24:0];
      phase_in = {phase_ff[2:0], start};
      sign_in = start ? rate_dt[25] : sign_ff;
      mag_in = start ? mag : mag_ff;
      prod_mag = 51'(mag_ff) * 51'(RECIP_MAG);
      qm_in = prod_mag[50:39];
      qm_scaled = 26'(qm_ff) * 26'(SCALE_DIV);
      rem_full = mag_ff - qm_scaled[24:0];
      rm_in = rem_full[13:0];
      prod_rem = 55'({rm_ff, ROUND_LOW}) * 55'(RECIP_REM);
      q_in = {qm_ff, prod_rem[53:41]};
      acc_in = acc_ff;
      delta = sign_ff ? -$signed({2'b00, q_ff}) : $signed({2'b00, q_ff});
      yaw = $signed({2'b00, acc_ff}) + delta;
      if (phase_ff[3]) begin
         if (yaw > FULL_TURN) begin
            acc_in = YAW_W'(yaw - FULL_TURN);
         end else if (yaw < 0) begin
            acc_in = YAW_W'(yaw + FULL_TURN);
         end else begin
            acc_in = YAW_W'(yaw);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         acc_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         acc_ff <= acc_in;
      end
      sign_ff <= sign_in;
      mag_ff <= mag_in;
      qm_ff <= qm_in;
      rm_ff <= rm_in;
      q_ff <= q_in;
   end

   assign rounded = acc_ff + YAW_W'(256);
   assign yaw_angle = rounded[YAW_W-1:9];

endmodule

FILE: hw/rtl/tilt_and_yaw_estimator_core.sv
// Top level of the tilt and yaw estimator: sequencer, square roots and CORDIC chains.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  accel x, y, z, gyro z, tick
//   rsp_      out        rsp_valid / rsp_ready  roll, pitch, yaw angles
//
// A request passes from acceptance to its response through the squaring step, the start
// of the square roots, sixteen root steps, the chain of sixteen CORDIC cells and the
// angle register, and the load of the response, which waits while a response is stalled.
// The yaw scaling runs alongside and finishes earlier. One request is in work at a
// time; the next is taken once the response is registered.
// Reset clears the yaw accumulator and the previous tick. A stalled response holds.
module tilt_and_yaw_estimator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_z,
   input  logic [31:0]        req_tick_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [tye_pkg::ANGLE_OUT_W-1:0] rsp_roll_angle,
   output logic signed [tye_pkg::ANGLE_OUT_W-1:0] rsp_pitch_angle,
   output logic [tye_pkg::YAW_OUT_W-1:0]          rsp_yaw_angle
);
   import tye_pkg::*;

   state_type state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [31:0] last_tick_ff;
   logic [31:0] diff;
   logic signed [15:0] ax_ff, ay_ff, az_ff, gz_ff;
   logic [9:0] dt_ff;
   logic signed [31:0] sq_ax, sq_ay, sq_az;
   logic [31:0] sq_ax_ff, sq_ay_ff, sq_az_ff;
   logic signed [25:0] rate_dt, rate_dt_ff;
   logic [15:0] root_roll, root_pitch;
   logic accept, start, inject, rsp_load, chain_done;
   logic signed [ANGLE_OUT_W-1:0] roll_hold_ff, pitch_hold_ff;
   logic rsp_valid_ff;
   logic signed [ANGLE_OUT_W-1:0] rsp_roll_ff, rsp_pitch_ff;
   logic [YAW_OUT_W-1:0] rsp_yaw_ff, yaw_angle;
   logic signed [16:0] neg_ax;
   cordic_lane_type roll_chain [CORDIC_STAGES+1];
   cordic_lane_type pitch_chain [CORDIC_STAGES+1];

   assign accept = req_valid && req_ready;
   assign chain_done = roll_chain[CORDIC_STAGES].valid;
   assign diff = req_tick_ms - last_tick_ff;
   assign sq_ax = 32'(ax_ff) * 32'(ax_ff);
   assign sq_ay = 32'(ay_ff) * 32'(ay_ff);
   assign sq_az = 32'(az_ff) * 32'(az_ff);
   assign rate_dt = 26'(gz_ff) * 26'($signed({1'b0, dt_ff}));
   assign neg_ax = -$signed({ax_ff[15], ax_ff});

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_ROOT;
            cnt_in = '0;
         end
         ST_ROOT: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = ST_ROTATE;
               cnt_in = '0;
            end
         end
         ST_ROTATE: begin
            cnt_in = 4'd1;
            if (chain_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      start = 1'b0;
      inject = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_START: start = 1'b1;
         ST_ROTATE: inject = (cnt_ff == 4'd0);
         ST_DONE: rsp_load = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_tick_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            last_tick_ff <= req_tick_ms;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      cnt_ff <= cnt_in;
      if (accept) begin
         ax_ff <= req_accel_x;
         ay_ff <= req_accel_y;
         az_ff <= req_accel_z;
         gz_ff <= req_gyro_z;
         dt_ff <= (diff > DT_LIMIT) ? DT_LIMIT[9:0] : diff[9:0];
      end
      sq_ax_ff <= sq_ax;
      sq_ay_ff <= sq_ay;
      sq_az_ff <= sq_az;
      rate_dt_ff <= rate_dt;
      if (chain_done) begin
         roll_hold_ff <= angle_out(roll_chain[CORDIC_STAGES].z,
                                   roll_chain[CORDIC_STAGES].zero);
         pitch_hold_ff <= angle_out(pitch_chain[CORDIC_STAGES].z,
                                    pitch_chain[CORDIC_STAGES].zero);
      end
      if (rsp_load) begin
         rsp_roll_ff <= roll_hold_ff;
         rsp_pitch_ff <= pitch_hold_ff;
         rsp_yaw_ff <= yaw_angle;
      end
   end

   tye_isqrt u_root_roll (
      .clock   (clock),
      .start   (start),
      .operand (sq_ax_ff + sq_az_ff),
      .root    (root_roll)
   );

   tye_isqrt u_root_pitch (
      .clock   (clock),
      .start   (start),
      .operand (sq_ay_ff + sq_az_ff),
      .root    (root_pitch)
   );

   tye_yaw u_yaw (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .rate_dt   (rate_dt_ff),
      .yaw_angle (yaw_angle)
   );

   always_comb begin
      roll_chain[0].valid = inject;
      roll_chain[0].zero = (root_roll == 16'd0) && (ay_ff == 16'sd0);
      roll_chain[0].x = $signed({3'b000, root_roll, 14'd0});
      roll_chain[0].y = $signed({{3{ay_ff[15]}}, ay_ff, 14'd0});
      roll_chain[0].z = '0;
      pitch_chain[0].valid = inject;
      pitch_chain[0].zero = (root_pitch == 16'd0) && (neg_ax == 17'sd0);
      pitch_chain[0].x = $signed({3'b000, root_pitch, 14'd0});
      pitch_chain[0].y = $signed({{2{neg_ax[16]}}, neg_ax, 14'd0});
      pitch_chain[0].z = '0;
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      tye_cordic_cell #(.STAGE(i)) u_roll_cell (
         .clock  (clock),
         .reset  (reset),
         .lane_i (roll_chain[i]),
         .lane_o (roll_chain[i+1])
      );
      tye_cordic_cell #(.STAGE(i)) u_pitch_cell (
         .clock  (clock),
         .reset  (reset),
         .lane_i (pitch_chain[i]),
         .lane_o (pitch_chain[i+1])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_roll_angle = rsp_roll_ff;
   assign rsp_pitch_angle = rsp_pitch_ff;
   assign rsp_yaw_angle = rsp_yaw_ff;

endmodule

FILE: bench/tilt_and_yaw_estimator_core_tb.sv
// Testbench of the tilt and yaw estimator: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module tilt_and_yaw_estimator_core_tb;
   import tye_pkg::*;

   typedef struct packed {
      logic signed [14:0] roll;
      logic signed [14:0] pitch;
      logic [15:0]        yaw;
   } angles_type;

   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_accel_x = '0;
   logic signed [15:0] req_accel_y = '0;
   logic signed [15:0] req_accel_z = '0;
   logic signed [15:0] req_gyro_z = '0;
   logic [31:0] req_tick_ms = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [ANGLE_OUT_W-1:0] rsp_roll_angle;
   logic signed [ANGLE_OUT_W-1:0] rsp_pitch_angle;
   logic [YAW_OUT_W-1:0] rsp_yaw_angle;

   angles_type expected_angles[$];
   logic [31:0] prev_tick;
   longint yaw_sum;
   int mismatches = 0;
   int responses = 0;
   int requests = 0;
   longint cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_off = 1'b0;
   logic [31:0] tick_now = '0;

   tilt_and_yaw_estimator_core DUT (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic longint floor_shift(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint int_root(longint n);
      longint r;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n) begin
            r = r + (longint'(1) << b);
         end
      end
      return r;
   endfunction

   function automatic longint tilt_angle(longint y0, longint x0);
      longint x, y, z, xs, ys, r;
      if (x0 == 0 && y0 == 0) begin
         return 0;
      end
      x = x0 * 16384;
      y = y0 * 16384;
      z = 0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_TAB[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_TAB[i];
         end
      end
      r = floor_shift(z + 256, 9);
      if (r > 11520) r = 11520;
      if (r < -11520) r = -11520;
      return r;
   endfunction

   function automatic angles_type predict_angles(longint ax, longint ay, longint az,
                                                 longint gz, logic [31:0] tick);
      angles_type a;
      logic [31:0] dt;
      longint num, delta, yaw;
      a.roll = 15'(tilt_angle(ay, int_root(ax * ax + az * az)));
      a.pitch = 15'(tilt_angle(-ax, int_root(ay * ay + az * az)));
      dt = tick - prev_tick;
      if (dt > 1000) dt = 1000;
      prev_tick = tick;
      num = gz * longint'(dt) * 65536;
      if (num >= 0) delta = (num + 65500) / 131000;
      else delta = -((-num + 65500) / 131000);
      yaw = yaw_sum + delta;
      if (yaw > 23592960) yaw = yaw - 23592960;
      else if (yaw < 0) yaw = yaw + 23592960;
      yaw_sum = yaw & 64'h1FFFFFF;
      a.yaw = 16'((yaw_sum + 256) >> 9);
      return a;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
   endtask

   task automatic send_request(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input logic [15:0] gz,
                               input logic [31:0] tick);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid <= 1'b1;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      req_gyro_z <= gz;
      req_tick_ms <= tick;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_angles.push_back(predict_angles($signed(ax), $signed(ay), $signed(az),
                                               $signed(gz), tick));
      requests++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (reset || hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      angles_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses++;
         if (expected_angles.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = expected_angles.pop_front();
            if (rsp_roll_angle !== want.roll)
               report_mismatch("roll", rsp_roll_angle, want.roll);
            if (rsp_pitch_angle !== want.pitch)
               report_mismatch("pitch", rsp_pitch_angle, want.pitch);
            if (rsp_yaw_angle !== want.yaw)
               report_mismatch("yaw", rsp_yaw_angle, want.yaw);
         end
      end
   end

   task automatic advance_tick();
      case ($urandom_range(9))
         0: tick_now = $urandom;
         1: tick_now = tick_now + $urandom_range(1001, 5000);
         2: tick_now = tick_now - $urandom_range(1, 3);
         default: tick_now = tick_now + $urandom_range(0, 1000);
      endcase
   endtask

   task automatic test_directed();
      logic [15:0] ext [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
      send_request(0, 0, 0, 0, 0);
      send_request(0, 0, 16384, 32767, 1000);
      send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, 2000);
      send_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF);
      send_request(0, 16'h7FFF, 0, 16'h7FFF, 32'd500);
      send_request(0, 16'h8000, 0, 16'h8000, 32'd1500);
      send_request(16'h7FFF, 0, 0, 16'h8000, 32'd1499);
      send_request(16'h8000, 0, 0, 16'h7FFF, 32'd2499);
      for (int i = 0; i < 5; i++) begin
         send_request(ext[i], ext[(i + 1) % 5], ext[(i + 2) % 5], 16'h7FFF,
                      32'd3000 + 32'(i) * 1000);
      end
      for (int i = 0; i < 8; i++) begin
         send_request(16'h0100, 16'hFF00, 16'h4000, 16'h8000, 32'd9000 + 32'(i) * 1000);
      end
      tick_now = 32'd20000;
   endtask

   task automatic test_random(input int count);
      logic [15:0] ax, ay, az;
      for (int i = 0; i < count; i++) begin
         advance_tick();
         ax = $urandom;
         ay = $urandom;
         az = $urandom;
         if ($urandom_range(3) == 0) begin
            ax = $signed(ax) >>> $urandom_range(15);
            ay = $signed(ay) >>> $urandom_range(15);
            az = $signed(az) >>> $urandom_range(15);
         end
         send_request(ax, ay, az, $urandom, tick_now);
      end
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         test_random(6);
         begin
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
      join
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      prev_tick = '0;
      yaw_sum = 0;
      send_idle_pct = 24;
      recv_idle_pct = 49;
      test_directed();
      test_random(380);
      test_backpressure();
      send_idle_pct = 49;
      recv_idle_pct = 24;
      test_random(380);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(380);
      while (expected_angles.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d requests and %0d responses: extremes, zero vectors, tick wrap,",
               requests, responses);
      $display("long time gaps, yaw wrap, random idling and a long receiver hold-off.");
      if (mismatches == 0 && expected_angles.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/tye_pkg.sv
hw/rtl/tye_isqrt.sv
hw/rtl/tye_cordic_cell.sv
hw/rtl/tye_yaw.sv
hw/rtl/tilt_and_yaw_estimator_core.sv
bench/tilt_and_yaw_estimator_core_tb.sv
